[rtl/core/indexed_min_heap_core_defines.svh]
// Assertion macros shared by the indexed min-heap core.
// Depends on nothing; included by the top level.
`ifndef INDEXED_MIN_HEAP_CORE_DEFINES_SVH
`define INDEXED_MIN_HEAP_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define IMH_ASSERT_IMP(label, clk_s, rstn_s, cond, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |-> (prop)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define IMH_ASSERT_NEXT(label, clk_s, rstn_s, cond, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |=> (prop)) \
    else $error(msg);
`endif

[rtl/core/imh_pkg.sv]
// Package for the indexed min-heap core: payload types, codes and states.
// Depends on nothing.
package imh_pkg;
  localparam int NodeCountDefault = 1024;
  localparam int IdW     = 10;
  localparam int WeightW = 32;
  localparam int CountW  = 11;

  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0, MODE_APPEND = 3'd1, MODE_CHANGE = 3'd2,
    MODE_POP = 3'd3, MODE_BUILD = 3'd4, MODE_QUERY = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_FULL = 3'd1, ST_DUP = 3'd2, ST_ABSENT = 3'd3, ST_EMPTY = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]                mode;
    logic [IdW-1:0]            node_id;
    logic signed [WeightW-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0]            top_id;
    logic signed [WeightW-1:0] top_weight;
    logic                      is_empty;
    logic [CountW-1:0]         entry_count;
    logic [2:0]                status;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_POSRD, S_POSWT, S_CHK, S_WRNEW,
    S_UPRD, S_UPWT, S_UPCMP,
    S_DNRD, S_DNWT, S_DNCMP, S_DNSWAP,
    S_POPRD, S_POPWT, S_POPWR,
    S_BLDNEXT, S_TOPRD, S_TOPWT, S_OUT
  } fsm_t;
endpackage

[rtl/core/indexed_min_heap_core.sv]
// Indexed min-heap core top level: memories, sift sequencer and result register.
// Depends on imh_pkg and indexed_min_heap_core_defines.svh.
//
// The block keeps a binary min-heap of node ids keyed by signed 32-bit weights,
// plus a map from id to heap slot. The heap slots live in one memory with one
// write port and two registered read ports, and the map in a second memory with
// one write and one registered read port. Each item is one operation (insert,
// append, change weight, pop, build, query) and gives exactly one result item
// with the root, the entry count and a status. Items are handled one at a time.
// A query, a pop on an empty heap, an out-of-range id or an unknown mode takes
// the shortest path; a duplicate, absent or full error and a change to the same
// weight first read the map and the slot, and an append then also writes the new
// entry. Every sift level has a read, a wait and a compare with write back. A pop
// sifts down by at most log2(N) - 1 moves and skips the sift when it removes the
// last entry. A build runs one down-sift per interior slot. After reset a clearing
// pass walks the whole position map, one entry per cycle, while in_ready stays low.
// The result register parts the two sides: a result that waits for out_ready does
// not block the next accept, and the next item only stalls when its own result is
// ready to be parked while the register is full.
`include "indexed_min_heap_core_defines.svh"
module indexed_min_heap_core #(
  parameter int NODE_COUNT = imh_pkg::NodeCountDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  imh_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output imh_pkg::out_item_t out_data
);
  import imh_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);
  localparam int FW = $clog2(NODE_COUNT + 1);
  localparam logic [FW-1:0] FULL_CNT = FW'(NODE_COUNT);

  // Heap slot memories and the position map (presence bit above slot index).
  logic [IdW-1:0]     sid_mem [NODE_COUNT];
  logic [WeightW-1:0] swt_mem [NODE_COUNT];
  logic [AW:0]        pos_mem [NODE_COUNT];

  // Slot memory: port A reads or writes one slot a cycle, port B only reads.
  logic          a_we;
  logic [AW-1:0] a_addr, b_addr;
  logic [IdW-1:0] a_wid, a_rid_r, b_rid_r;
  logic signed [WeightW-1:0] a_ww, a_rw_r, b_rw_r;
  // Position map: one write port, one read port.
  logic          p_we;
  logic [AW-1:0] p_waddr, p_raddr;
  logic [AW:0]   p_wdata, p_rdata_r;

  always_ff @(posedge clk) begin
    if (a_we) begin
      sid_mem[a_addr] <= a_wid;
      swt_mem[a_addr] <= a_ww;
    end
    a_rid_r <= sid_mem[a_addr];
    a_rw_r  <= swt_mem[a_addr];
    b_rid_r <= sid_mem[b_addr];
    b_rw_r  <= swt_mem[b_addr];
  end
  always_ff @(posedge clk) begin
    if (p_we) begin
      pos_mem[p_waddr] <= p_wdata;
    end
    p_rdata_r <= pos_mem[p_raddr];
  end

  // Control registers.
  fsm_t              st_r, st_nxt;
  logic              clr_r, clr_nxt;
  logic [AW-1:0]     clr_idx_r, clr_idx_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  in_item_t          req_r, req_nxt;
  logic [2:0]        stat_r, stat_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;     // slot being sifted
  logic [IdW-1:0]    cid_r, cid_nxt;     // id of the entry being sifted
  logic signed [WeightW-1:0] cw_r, cw_nxt; // its weight
  logic [AW-1:0]     bld_r, bld_nxt;     // next build index plus one
  logic              bld_on_r, bld_on_nxt;
  logic              ovalid_r, ovalid_nxt;
  out_item_t         odata_r, odata_nxt;

  // Child slot arithmetic, one bit wider to detect running past the fill.
  logic [FW:0] left_w, right_w;
  logic        has_left, has_right, pick_right;
  logic [AW-1:0] pick_a;
  logic signed [WeightW-1:0] pick_w;
  logic [IdW-1:0] pick_id;
  assign left_w    = (FW+1)'({pos_r, 1'b1});
  assign right_w   = left_w + (FW+1)'(1);
  assign has_left  = left_w  < {1'b0, fill_r};
  assign has_right = right_w < {1'b0, fill_r};
  assign pick_right = has_right && !(a_rw_r < b_rw_r);
  assign pick_a  = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
  assign pick_w  = pick_right ? b_rw_r : a_rw_r;
  assign pick_id = pick_right ? b_rid_r : a_rid_r;

  logic [AW-1:0] parent_a;
  assign parent_a = (pos_r - AW'(1)) >> 1;

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; clr_idx_nxt = clr_idx_r;
    fill_nxt = fill_r; req_nxt = req_r; stat_nxt = stat_r;
    pos_nxt = pos_r; cid_nxt = cid_r; cw_nxt = cw_r;
    bld_nxt = bld_r; bld_on_nxt = bld_on_r;
    ovalid_nxt = ovalid_r; odata_nxt = odata_r;
    a_we = 1'b0; p_we = 1'b0;
    a_addr = pos_r; b_addr = pos_r;
    a_wid = cid_r; a_ww = cw_r;
    p_waddr = clr_idx_r; p_wdata = '0; p_raddr = AW'(req_r.node_id);
    in_ready = 1'b0;

    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;

    if (clr_r) begin
      p_we = 1'b1;
      clr_idx_nxt = clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(NODE_COUNT - 1)) clr_nxt = 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          in_ready = 1'b1;
          if (in_valid && in_ready) begin
            req_nxt  = in_data;
            stat_nxt = ST_OK;
            case (in_data.mode)
              MODE_INSERT, MODE_APPEND, MODE_CHANGE: begin
                if (32'(in_data.node_id) >= 32'(NODE_COUNT)) begin
                  stat_nxt = ST_ABSENT;
                  st_nxt   = S_TOPRD;
                end else st_nxt = S_POSRD;
              end
              MODE_POP: begin
                if (fill_r == '0) begin
                  stat_nxt = ST_EMPTY;
                  st_nxt   = S_TOPRD;
                end else st_nxt = S_POPRD;
              end
              MODE_BUILD: begin
                bld_nxt    = AW'(fill_r >> 1);
                bld_on_nxt = 1'b1;
                st_nxt     = S_BLDNEXT;
              end
              default: st_nxt = S_TOPRD;
            endcase
          end
        end
        S_POSRD: begin
          p_raddr = AW'(req_r.node_id);
          st_nxt  = S_POSWT;
        end
        S_POSWT: begin
          a_addr = p_rdata_r[AW-1:0];
          st_nxt = S_CHK;
        end
        S_CHK: begin
          cid_nxt = req_r.node_id;
          cw_nxt  = req_r.weight;
          if (req_r.mode == MODE_CHANGE) begin
            if (!p_rdata_r[AW]) begin
              stat_nxt = ST_ABSENT; st_nxt = S_TOPRD;
            end else begin
              pos_nxt = p_rdata_r[AW-1:0];
              if (a_rw_r == req_r.weight) st_nxt = S_TOPRD;
              else if (a_rw_r < req_r.weight) st_nxt = S_DNRD;
              else st_nxt = S_UPRD;
            end
          end else if (p_rdata_r[AW]) begin
            stat_nxt = ST_DUP; st_nxt = S_TOPRD;
          end else if (fill_r >= FULL_CNT) begin
            stat_nxt = ST_FULL; st_nxt = S_TOPRD;
          end else begin
            pos_nxt  = fill_r[AW-1:0];
            fill_nxt = fill_r + FW'(1);
            st_nxt   = (req_r.mode == MODE_INSERT) ? S_UPRD : S_WRNEW;
          end
        end
        S_WRNEW: begin
          // Append: place the entry at its slot with no ordering.
          a_we = 1'b1; a_addr = pos_r;
          p_we = 1'b1; p_waddr = AW'(cid_r); p_wdata = {1'b1, pos_r};
          st_nxt = S_TOPRD;
        end
        S_UPRD: begin
          b_addr = parent_a;
          st_nxt = S_UPWT;
        end
        S_UPWT: begin
          b_addr = parent_a;
          st_nxt = S_UPCMP;
        end
        S_UPCMP: begin
          if (pos_r != '0 && cw_r < b_rw_r) begin
            // Parent moves down into the current slot.
            a_we = 1'b1; a_addr = pos_r; a_wid = b_rid_r; a_ww = b_rw_r;
            p_we = 1'b1; p_waddr = AW'(b_rid_r); p_wdata = {1'b1, pos_r};
            pos_nxt = parent_a;
            st_nxt  = S_UPRD;
          end else begin
            a_we = 1'b1; a_addr = pos_r;
            p_we = 1'b1; p_waddr = AW'(cid_r); p_wdata = {1'b1, pos_r};
            st_nxt = bld_on_r ? S_BLDNEXT : S_TOPRD;
          end
        end
        S_DNRD: begin
          a_addr = left_w[AW-1:0];
          b_addr = has_right ? right_w[AW-1:0] : left_w[AW-1:0];
          st_nxt = S_DNWT;
        end
        S_DNWT: begin
          a_addr = left_w[AW-1:0];
          b_addr = has_right ? right_w[AW-1:0] : left_w[AW-1:0];
          st_nxt = S_DNCMP;
        end
        S_DNCMP: begin
          if (has_left && !(cw_r < pick_w)) begin
            a_we = 1'b1; a_addr = pos_r; a_wid = pick_id; a_ww = pick_w;
            p_we = 1'b1; p_waddr = AW'(pick_id); p_wdata = {1'b1, pos_r};
            pos_nxt = pick_a;
            st_nxt  = S_DNRD;
          end else begin
            a_we = 1'b1; a_addr = pos_r;
            p_we = 1'b1; p_waddr = AW'(cid_r); p_wdata = {1'b1, pos_r};
            st_nxt = bld_on_r ? S_BLDNEXT : S_TOPRD;
          end
        end
        S_DNSWAP: st_nxt = S_TOPRD;
        S_POPRD: begin
          a_addr = '0;
          b_addr = AW'(fill_r - FW'(1));
          st_nxt = S_POPWT;
        end
        S_POPWT: begin
          a_addr = '0;
          b_addr = AW'(fill_r - FW'(1));
          st_nxt = S_POPWR;
        end
        S_POPWR: begin
          // Old root leaves the map; any other last entry sifts down from the root.
          p_we = 1'b1; p_waddr = AW'(a_rid_r); p_wdata = '0;
          fill_nxt = fill_r - FW'(1);
          cid_nxt = b_rid_r; cw_nxt = b_rw_r; pos_nxt = '0;
          st_nxt = (fill_r == FW'(1)) ? S_TOPRD : S_DNRD;
        end
        S_BLDNEXT: begin
          if (bld_r == '0) begin
            bld_on_nxt = 1'b0;
            st_nxt = S_TOPRD;
          end else begin
            a_addr  = bld_r - AW'(1);
            pos_nxt = bld_r - AW'(1);
            bld_nxt = bld_r - AW'(1);
            st_nxt  = S_TOPWT;
          end
        end
        S_TOPRD: begin
          a_addr = '0;
          st_nxt = S_TOPWT;
        end
        S_TOPWT: begin
          a_addr = '0;
          if (bld_on_r) begin
            // Entry at the build index is now loaded; start its down-sift.
            cid_nxt = a_rid_r; cw_nxt = a_rw_r;
            st_nxt  = S_DNRD;
          end else begin
            st_nxt = S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid_r || out_ready) begin
            ovalid_nxt = 1'b1;
            odata_nxt.is_empty    = (fill_r == '0);
            odata_nxt.top_id      = (fill_r == '0) ? '0 : a_rid_r;
            odata_nxt.top_weight  = (fill_r == '0) ? '0 : a_rw_r;
            odata_nxt.entry_count = CountW'(fill_r);
            odata_nxt.status      = stat_r;
            st_nxt = S_IDLE;
          end else a_addr = '0;
        end
        default: st_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; clr_r <= 1'b1; clr_idx_r <= '0; fill_r <= '0;
      bld_on_r <= 1'b0; ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; clr_idx_r <= clr_idx_nxt; fill_r <= fill_nxt;
      bld_on_r <= bld_on_nxt; ovalid_r <= ovalid_nxt;
    end
  end
  always_ff @(posedge clk) begin
    req_r <= req_nxt; stat_r <= stat_nxt; pos_r <= pos_nxt; cid_r <= cid_nxt;
    cw_r <= cw_nxt; bld_r <= bld_nxt; odata_r <= odata_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  `IMH_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FULL_CNT, "fill count exceeds depth")
  `IMH_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, clr_r, !in_ready, "accept during clear")
  `IMH_ASSERT_NEXT(a_empty_flag, clk, rst_n, st_r == S_OUT && ovalid_nxt && !ovalid_r,
    out_data.is_empty == (out_data.entry_count == '0), "empty flag mismatch")
endmodule
